/* rtl/sgig_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgig_pkg
// Shared widths, register indexes and types of the stitched grid index
// generator.
// ---------------------------------------------------------------------------
package sgig_pkg;

  localparam int COORD_W   = 8;   // quad row / column
  localparam int VTX_W     = 16;  // vertex index, wraps mod 2^16
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 8;   // widest register

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [VTX_W-1:0]     vtx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DW-1:0]    cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_QUADS  = 2'd0;
  localparam cfg_idx_t REG_JOIN_X = 2'd1;
  localparam cfg_idx_t REG_JOIN_Z = 2'd2;

  // join side bits
  localparam int SIDE_NEG = 0;
  localparam int SIDE_POS = 1;

  localparam coord_t QUADS_RST = 8'd64;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  // per-quad edge decode carried from decode stage to corner stage
  typedef struct packed {
    logic flip;
    logic ex0;    // widen first triangle along x (positive z stitch)
    logic ez0;    // widen first triangle corner b along z
    logic ez1;    // widen first triangle corner a along z
    logic ex1;    // widen second triangle along x (negative z stitch)
    logic keep0;
    logic keep1;
  } quad_flags_t;

endpackage

/* rtl/stitched_grid_index_generator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stitched_grid_index_generator
// Turns one grid quad request into up to two stitched triangles of vertex
// indices, snake ordered, over a five-register pipeline.
// ---------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  request | in_quad_row, in_loop_column             | start && !busy
//  result  | out_corner_a/b/c, out_which_triangle,   | out_valid, 1 cycle
//          | out_last                                |
//  config  | cfg_index, cfg_wdata                    | cfg_we
//
// The first triangle reaches the result ports through the stage 1, stage 2,
// stage 3, stage 4 and output registers; the second follows in the next
// cycle. One triangle leaves per cycle, so a quad with two triangles holds
// the emit stage until its second has left; one with one or none does not.
// busy rises when the emit stage holds two pending triangles and the stages
// behind it are full; nothing is dropped or repeated. Synchronous reset
// empties the pipeline and loads quads_per_side = 64, join sides = 0.
// ---------------------------------------------------------------------------
module stitched_grid_index_generator #(
  parameter int MAX_QUADS = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sgig_pkg::coord_t    in_quad_row,
  input  sgig_pkg::coord_t    in_loop_column,
  output logic                out_valid,
  output sgig_pkg::vtx_t      out_corner_a,
  output sgig_pkg::vtx_t      out_corner_b,
  output sgig_pkg::vtx_t      out_corner_c,
  output logic                out_which_triangle,
  output logic                out_last,
  input  logic                cfg_we,
  input  sgig_pkg::cfg_idx_t  cfg_index,
  input  sgig_pkg::cfg_data_t cfg_wdata
);
  import sgig_pkg::*;

  localparam coord_t QMAX = COORD_W'(MAX_QUADS);

  // configuration
  coord_t     quads_r;
  logic [1:0] join_x_r;
  logic [1:0] join_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quads_r  <= QUADS_RST;
      join_x_r <= '0;
      join_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUADS:  quads_r  <= (cfg_wdata > QMAX) ? QMAX : cfg_wdata;
        REG_JOIN_X: join_x_r <= cfg_wdata[1:0];
        REG_JOIN_Z: join_z_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [COORD_W:0] width_v;  // vertices per row
  assign width_v = {1'b0, quads_r} + {{COORD_W{1'b0}}, 1'b1};

  // pipeline control
  logic s1_v_r, s2_v_r, s3_v_r;
  logic p0_r, p1_r;           // pending triangles in emit stage
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  assign rdy4   = !(p0_r && p1_r);
  assign rdy3   = !s3_v_r || rdy4;
  assign rdy2   = !s2_v_r || rdy3;
  assign rdy1   = !s1_v_r || rdy2;
  assign busy   = !rdy1;
  assign accept = start && rdy1;

  // stage 1: request capture
  coord_t z1_r, x1_r;
  always_ff @(posedge clk) begin
    if (rdy1) begin
      z1_r <= in_quad_row;
      x1_r <= in_loop_column;
    end
  end

  // stage 2: range check, snake mirror, edge decode
  logic        in_grid;
  logic        zodd, top, bottom, left, right;
  coord_t      xs;
  quad_flags_t fl_nxt;

  always_comb begin
    in_grid = (z1_r < quads_r) && (x1_r < quads_r);
    zodd    = z1_r[0];
    xs      = zodd ? (quads_r - COORD_W'(1) - x1_r) : x1_r;
    top     = (z1_r == quads_r - COORD_W'(1));
    bottom  = (z1_r == '0);
    left    = (xs == '0);
    right   = (xs == quads_r - COORD_W'(1));
    fl_nxt.flip  = xs[0] ^ z1_r[0];
    fl_nxt.ex0   = join_z_r[SIDE_POS] && top;
    fl_nxt.ez0   = join_x_r[SIDE_NEG] && left && !zodd;
    fl_nxt.ez1   = join_x_r[SIDE_POS] && right && !zodd;
    fl_nxt.ex1   = join_z_r[SIDE_NEG] && bottom;
    fl_nxt.keep0 = !(join_z_r[SIDE_POS] && xs[0] && top);
    fl_nxt.keep1 = !(join_z_r[SIDE_NEG] && xs[0] && bottom)
                && !(join_x_r[SIDE_NEG] && zodd && left)
                && !(join_x_r[SIDE_POS] && zodd && right);
  end

  coord_t      z2_r, xs2_r;
  quad_flags_t fl2_r;
  always_ff @(posedge clk) begin
    if (rdy2) begin
      z2_r  <= z1_r;
      xs2_r <= xs;
      fl2_r <= fl_nxt;
    end
  end

  // stage 3: row base z * w
  logic [2*COORD_W:0] row_prod;
  assign row_prod = {{(COORD_W+1){1'b0}}, z2_r} * {{COORD_W{1'b0}}, width_v};

  vtx_t        zw3_r;
  coord_t      xs3_r;
  quad_flags_t fl3_r;
  always_ff @(posedge clk) begin
    if (rdy3) begin
      zw3_r <= row_prod[VTX_W-1:0];
      xs3_r <= xs2_r;
      fl3_r <= fl2_r;
    end
  end

  // stage 4: corner sums, then serialize
  vtx_t wv, xv, base, base_up;
  tri_t t0_nxt, t1_nxt;
  always_comb begin
    wv      = VTX_W'(width_v);
    xv      = VTX_W'(xs3_r);
    base    = zw3_r + xv;
    base_up = base + wv;
    t0_nxt.a = base_up + (fl3_r.ez1 ? wv : '0) + VTX_W'(1) + VTX_W'(fl3_r.ex0);
    t0_nxt.b = base_up + (fl3_r.ez0 ? wv : '0);
    t0_nxt.c = base + VTX_W'(fl3_r.flip);
    t1_nxt.a = base + VTX_W'(1) + VTX_W'(fl3_r.ex1);
    t1_nxt.b = base_up + VTX_W'(1) - VTX_W'(fl3_r.flip);
    t1_nxt.c = base;
  end

  tri_t t0_r, t1_r;
  logic load4;
  assign load4 = s3_v_r && rdy4;

  always_ff @(posedge clk) begin
    if (load4) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
    end
  end

  // output register
  logic out_v_r;
  tri_t out_t_r;
  logic out_which_r, out_last_r;

  always_ff @(posedge clk) begin
    if (p0_r) begin
      out_t_r     <= t0_r;
      out_which_r <= 1'b0;
      out_last_r  <= !p1_r;
    end else begin
      out_t_r     <= t1_r;
      out_which_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  // valid bits
  logic p0_nxt, p1_nxt;
  always_comb begin
    p0_nxt = 1'b0;
    p1_nxt = p1_r && p0_r;
    if (load4) begin
      p0_nxt = fl3_r.keep0;
      p1_nxt = fl3_r.keep1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      p0_r    <= 1'b0;
      p1_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= accept;
      if (rdy2) s2_v_r <= s1_v_r && in_grid;
      if (rdy3) s3_v_r <= s2_v_r;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      out_v_r <= p0_r || p1_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_corner_a       = out_t_r.a;
  assign out_corner_b       = out_t_r.b;
  assign out_corner_c       = out_t_r.c;
  assign out_which_triangle = out_which_r;
  assign out_last           = out_last_r;

endmodule

/* rtl/sgig_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgig_checker
// Port-level checks of the stitched grid index generator's triangle stream.
// ---------------------------------------------------------------------------
module sgig_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_which_triangle,
  input logic out_last
);

  // pipeline empties on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result or busy right after reset");

  // second triangle always closes its quad
  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_which_triangle |-> out_last)
    else $error("second triangle not marked last");

  // an open quad gets its second triangle in the very next cycle
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_which_triangle)
    else $error("second triangle missing after open quad");

  // a non-last triangle is always the first of its quad
  a_open_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_which_triangle)
    else $error("open quad on second triangle");

endmodule

bind stitched_grid_index_generator sgig_checker u_sgig_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_which_triangle(out_which_triangle),
  .out_last          (out_last)
);
